// ===== rtl/edd_pkg.sv =====
package edd_pkg;

  // Register map of the configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_LINE_WIDTH   = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam int LINE_WIDTH_W   = 13;
  localparam int FRAME_HEIGHT_W = 16;
  localparam logic [LINE_WIDTH_W-1:0]   LINE_WIDTH_RESET   = 13'd640;
  localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 16'd480;

  localparam int MAX_WIDTH_DEFAULT = 4096;

  localparam int SAMPLE_W = 16;
  localparam int PIXEL_W  = 8;
  localparam int ERR_W    = 3;

  localparam logic signed [SAMPLE_W:0] ROUND_BIAS   = 17'sd8;
  localparam logic signed [13:0]       PIXEL_OFFSET = 14'sd128;
  localparam logic signed [13:0]       PIXEL_MAX    = 14'sd255;

endpackage

// ===== rtl/error_diffusion_dither.sv =====
// Error-diffusion dither: signed samples (value x16, centered on zero) arrive in
// raster order on the slave stream, one 8-bit pixel per sample leaves on the
// master stream with tlast on the last pixel of each row and tuser on the last
// pixel of the frame. Throughput is one pixel per clock while m_tready stays
// high (stages: input register, result register); the per-pixel error path is a
// 16-bit add, a shift and a clamp, and the line of errors for the next row sits
// in a MAX_WIDTH x 3 memory with one write and one read port. A per-frame fill
// count masks entries not yet written in the current frame, so the line store
// needs no clearing pass after reset or at frame end. line_width and
// frame_height may be written only while the block is idle; a value of zero
// acts as one, and a width above MAX_WIDTH acts as MAX_WIDTH.
module error_diffusion_dither
  import edd_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [SAMPLE_W-1:0]    s_tdata,   // [15:0] sample
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [PIXEL_W-1:0]     m_tdata,   // [7:0] pixel
  output logic                   m_tlast,   // end_of_line
  output logic                   m_tuser    // [0] end_of_frame
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int FW = $clog2(MAX_WIDTH + 1);

  // configuration
  logic [LINE_WIDTH_W-1:0]   line_width;
  logic [FRAME_HEIGHT_W-1:0] frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width   <= LINE_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LINE_WIDTH:   line_width   <= cfg_data[LINE_WIDTH_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[FRAME_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [FW-1:0]             width_eff;
  logic [FRAME_HEIGHT_W-1:0] height_eff;

  always_comb begin
    if (line_width == '0) begin
      width_eff = FW'(1);
    end else if (32'(line_width) > MAX_WIDTH) begin
      width_eff = FW'(MAX_WIDTH);
    end else begin
      width_eff = FW'(line_width);
    end
    height_eff = (frame_height == '0) ? FRAME_HEIGHT_W'(1) : frame_height;
  end

  // handshake
  logic s1_valid;
  logic advance;
  logic accept;

  assign advance  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || advance;
  assign accept   = s_tvalid && s_tready;

  // position counters, advanced per accepted transaction
  logic [AW-1:0]             col;
  logic [FRAME_HEIGHT_W-1:0] row;
  logic                      last_col;
  logic                      last_row;

  assign last_col = (FW'(col) + FW'(1)) >= width_eff;
  assign last_row = ({1'b0, row} + 17'd1) >= {1'b0, height_eff};

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (last_col) begin
        col <= '0;
        row <= last_row ? '0 : row + FRAME_HEIGHT_W'(1);
      end else begin
        col <= col + AW'(1);
      end
    end
  end

  // input register
  logic [SAMPLE_W-1:0] s1_sample;
  logic [AW-1:0]       s1_col;
  logic                s1_interior;
  logic                s1_last_col;
  logic                s1_eof;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample   <= s_tdata;
      s1_col      <= col;
      s1_interior <= (col != '0) && !last_col && !last_row;
      s1_last_col <= last_col;
      s1_eof      <= last_col && last_row;
    end
  end

  // error line store; the entry of the previous pixel is held in pend until
  // its lower-left share is known, then written back
  logic [ERR_W-1:0] line_mem [MAX_WIDTH];
  logic [ERR_W-1:0] rd_data;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [ERR_W-1:0] mem_wdata;

  logic             pend_valid;
  logic [AW-1:0]    pend_addr;
  logic [ERR_W-1:0] pend_val;
  logic [FW-1:0]    fill;
  logic [ERR_W-1:0] carry;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      // write-through when the read hits the entry written this cycle
      if (mem_we && mem_waddr == col) begin
        rd_data <= mem_wdata;
      end else begin
        rd_data <= line_mem[col];
      end
    end
  end

  // per-pixel arithmetic
  logic [ERR_W-1:0]           below_in;
  logic [SAMPLE_W-1:0]        sum;
  logic signed [SAMPLE_W:0]   t;
  logic signed [12:0]         q;
  logic signed [13:0]         qp;
  logic [3:0]                 r;
  logic [PIXEL_W-1:0]         pixel;
  logic [ERR_W-1:0]           err_right;
  logic [ERR_W-1:0]           err_lower;
  logic [ERR_W-1:0]           err_lower_left;

  always_comb begin
    if (pend_valid && pend_addr == s1_col) begin
      below_in = pend_val;
    end else if (FW'(s1_col) < fill) begin
      below_in = rd_data;
    end else begin
      below_in = '0;
    end
    sum = s1_sample + SAMPLE_W'(carry) + SAMPLE_W'(below_in);
    t   = $signed({sum[SAMPLE_W-1], sum}) + ROUND_BIAS;
    q   = 13'(t >>> 4);
    r   = t[3:0];
    qp  = 14'(q) + PIXEL_OFFSET;
    if (qp < 14'sd0) begin
      pixel = '0;
    end else if (qp > PIXEL_MAX) begin
      pixel = PIXEL_MAX[PIXEL_W-1:0];
    end else begin
      pixel = qp[PIXEL_W-1:0];
    end
    // r is 0..15, so r>>4 terms vanish and the lower-right share is always 0
    err_right      = s1_interior ? ERR_W'(r >> 1) : '0;
    err_lower      = s1_interior ? ERR_W'(r >> 2) : '0;
    err_lower_left = s1_interior ? ERR_W'(r >> 3) : '0;
  end

  assign mem_we    = advance && pend_valid;
  assign mem_waddr = pend_addr;
  assign mem_wdata = pend_val + err_lower_left;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      fill       <= '0;
      carry      <= '0;
    end else if (advance) begin
      carry <= err_right;
      if (s1_eof) begin
        pend_valid <= 1'b0;
        fill       <= '0;
      end else begin
        pend_valid <= 1'b1;
        if (FW'(s1_col) + FW'(1) > fill) begin
          fill <= FW'(s1_col) + FW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pend_addr <= s1_col;
      pend_val  <= err_lower;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= pixel;
      m_tlast <= s1_last_col;
      m_tuser <= s1_eof;
    end
  end

  // checks
  a_eof_is_eol: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_tuser || m_tlast))
    else $error("end of frame without end of line");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(MAX_WIDTH))
    else $error("fill count beyond line store depth");

  a_carry_row_end: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_last_col) |=> (carry == '0))
    else $error("right error carried across a row end");

  a_pend_left: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_interior) |-> (pend_valid && pend_addr == s1_col - AW'(1)))
    else $error("pending entry is not the left neighbor of an interior pixel");

endmodule

// ===== tb/tb_error_diffusion_dither.sv =====
`timescale 1ns / 1ps

module tb_error_diffusion_dither;
  import edd_pkg::*;

  localparam int MAX_W = MAX_WIDTH_DEFAULT;
  localparam int NUM_DIR = 36;
  localparam int NUM_PHASES = 12;
  localparam int PHASE_ITEMS = 158;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               eol;
    logic               eof;
  } pixel_t;

  typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t                kind;
    logic [CFG_INDEX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]    val;
    logic                     typed;
    pixel_t                   res;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [SAMPLE_W-1:0]    s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [PIXEL_W-1:0]     m_tdata;
  logic                   m_tlast;
  logic                   m_tuser;

  error_diffusion_dither DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always #10 clk = ~clk;

  // dither state mirror
  logic [LINE_WIDTH_W-1:0]   width_reg;
  logic [FRAME_HEIGHT_W-1:0] height_reg;
  logic [ERR_W-1:0]          below_err [0:MAX_W-1];
  logic [ERR_W-1:0]          right_err;
  int unsigned               col_cnt;
  int unsigned               row_cnt;

  pixel_t      pending_pixels [$];
  pixel_t      got_px;
  pixel_t      exp_px;
  int unsigned mismatches = 0;
  int unsigned src_idle = 0;
  int unsigned snk_idle = 0;

  stim_row_t dir_rows [NUM_DIR] = '{
    '{ROW_SAMPLE, '0, 16'h0000, 1'b1, '{8'd128, 1'b0, 1'b0}},
    '{ROW_SAMPLE, '0, 16'h8000, 1'b1, '{8'd0,   1'b0, 1'b0}},
    '{ROW_SAMPLE, '0, 16'h7FFF, 1'b0, '0},  // carry pushes past +32767, wraps
    '{ROW_SAMPLE, '0, 16'h7FF8, 1'b0, '0},
    // shrink width mid-frame
    '{ROW_CFG, REG_LINE_WIDTH,   16'd3, 1'b0, '0},
    '{ROW_CFG, REG_FRAME_HEIGHT, 16'd2, 1'b0, '0},
    '{ROW_SAMPLE, '0, 16'd100,  1'b0, '0},
    '{ROW_SAMPLE, '0, 16'hFFF8, 1'b0, '0},
    '{ROW_SAMPLE, '0, 16'd7,    1'b0, '0},
    '{ROW_SAMPLE, '0, 16'd1000, 1'b0, '0},
    '{ROW_SAMPLE, '0, 16'hFFFF, 1'b0, '0},
    '{ROW_SAMPLE, '0, 16'd5,    1'b0, '0},
    '{ROW_SAMPLE, '0, 16'd200,  1'b0, '0},
    // zero width and height act as a 1x1 frame
    '{ROW_CFG, REG_LINE_WIDTH,   16'd0, 1'b0, '0},
    '{ROW_CFG, REG_FRAME_HEIGHT, 16'd0, 1'b0, '0},
    '{ROW_SAMPLE, '0, 16'h7FFF, 1'b0, '0},
    '{ROW_SAMPLE, '0, 16'h7FFF, 1'b1, '{8'd255, 1'b1, 1'b1}},
    '{ROW_SAMPLE, '0, 16'h8000, 1'b1, '{8'd0,   1'b1, 1'b1}},
    '{ROW_SAMPLE, '0, 16'd8,    1'b1, '{8'd129, 1'b1, 1'b1}},
    '{ROW_SAMPLE, '0, 16'hFFF7, 1'b1, '{8'd127, 1'b1, 1'b1}},
    // width beyond the line store clamps to its size
    '{ROW_CFG, REG_LINE_WIDTH,   16'd8191, 1'b0, '0},
    '{ROW_CFG, REG_FRAME_HEIGHT, 16'd1,    1'b0, '0},
    '{ROW_SAMPLE, '0, 16'h7FFF, 1'b0, '0},
    '{ROW_SAMPLE, '0, 16'h0123, 1'b0, '0},
    '{ROW_CFG, REG_LINE_WIDTH,   16'd4096,  1'b0, '0},
    '{ROW_CFG, REG_FRAME_HEIGHT, 16'hFFFF,  1'b0, '0},
    '{ROW_SAMPLE, '0, 16'h7FFF, 1'b0, '0},
    '{ROW_SAMPLE, '0, 16'h8000, 1'b0, '0},
    // narrow rows: no interior pixels
    '{ROW_CFG, REG_LINE_WIDTH,   16'd1, 1'b0, '0},
    '{ROW_CFG, REG_FRAME_HEIGHT, 16'd3, 1'b0, '0},
    '{ROW_SAMPLE, '0, 16'd3,    1'b0, '0},
    '{ROW_SAMPLE, '0, 16'hFFF0, 1'b0, '0},
    '{ROW_SAMPLE, '0, 16'd9,    1'b0, '0},
    '{ROW_CFG, REG_LINE_WIDTH,   16'd2, 1'b0, '0},
    '{ROW_CFG, REG_FRAME_HEIGHT, 16'd2, 1'b0, '0},
    '{ROW_SAMPLE, '0, 16'd23,   1'b0, '0}
  };

  function automatic void clear_frame();
    for (int i = 0; i < MAX_W; i++) below_err[i] = '0;
    right_err = '0;
    col_cnt = 0;
    row_cnt = 0;
  endfunction

  function automatic pixel_t dither_pixel(input logic [SAMPLE_W-1:0] smp);
    int unsigned w, h, col, below_in, r;
    logic [SAMPLE_W-1:0] sum;
    int v, t, q, p;
    bit last_col, last_row, interior;
    pixel_t res;
    w = width_reg;
    h = height_reg;
    if (w == 0) w = 1;
    if (w > MAX_W) w = MAX_W;
    if (h == 0) h = 1;
    col = col_cnt;
    last_col = (col + 1 >= w);
    last_row = (row_cnt + 1 >= h);
    interior = (col != 0) && !last_col && !last_row;
    below_in = (col < MAX_W) ? below_err[col] : 0;
    sum = SAMPLE_W'(smp + right_err + below_in);
    v = $signed(sum);
    t = v + 8;
    q = t >>> 4;
    r = t - 16 * q;
    p = q + 128;
    if (p < 0) p = 0;
    if (p > 255) p = 255;
    if (interior) begin
      right_err = ERR_W'((r >> 1) - (r >> 4));
      below_err[col-1] = ERR_W'(below_err[col-1] + (r >> 3) + (r >> 4));
      below_err[col] = ERR_W'((r >> 2) + (r >> 4));
    end else begin
      right_err = '0;
      if (col < MAX_W) below_err[col] = '0;
    end
    res.pixel = p[PIXEL_W-1:0];
    res.eol = last_col;
    res.eof = last_col && last_row;
    if (last_col) begin
      col_cnt = 0;
      right_err = '0;
      if (last_row) clear_frame();
      else row_cnt = row_cnt + 1;
    end else begin
      col_cnt = col + 1;
    end
    return res;
  endfunction

  // called at a falling edge
  task automatic drain();
    s_tvalid = 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    drain();
    repeat (3) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_LINE_WIDTH) width_reg = val[LINE_WIDTH_W-1:0];
    else height_reg = val[FRAME_HEIGHT_W-1:0];
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input bit typed,
                             input pixel_t typed_res);
    pixel_t res;
    while ($urandom_range(99) < src_idle) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = smp;
    do @(posedge clk); while (!s_tready);
    res = dither_pixel(smp);
    pending_pixels.push_back(typed ? typed_res : res);
    @(negedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 50) return SAMPLE_W'($urandom_range(4095) - 2048);  // unclamped pixel range
    if (sel < 70) return SAMPLE_W'($urandom_range(63) - 32);
    if (sel < 85) return SAMPLE_W'($urandom_range(16'hFFFF));
    if (sel < 93) return SAMPLE_W'(16'h7FFF - $urandom_range(15));
    return SAMPLE_W'(16'h8000 + $urandom_range(15));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_width();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 60) return CFG_DATA_W'($urandom_range(16, 1));
    if (sel < 75) return CFG_DATA_W'($urandom_range(64, 17));
    if (sel < 82) return '0;
    if (sel < 88) return CFG_DATA_W'($urandom_range(8191, 4097));
    if (sel < 95) return CFG_DATA_W'($urandom_range(2, 1));
    return CFG_DATA_W'(MAX_W);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_height();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 55) return CFG_DATA_W'($urandom_range(5, 1));
    if (sel < 70) return CFG_DATA_W'($urandom_range(40, 6));
    if (sel < 80) return '0;
    if (sel < 90) return 16'hFFFF;
    return CFG_DATA_W'(1);
  endfunction

  always @(negedge clk) m_tready = ($urandom_range(99) >= snk_idle);

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_px = '{m_tdata, m_tlast, m_tuser};
      if (pending_pixels.size() == 0) begin
        $display("%0t: pixel transaction with none pending: expected none, got %0d/%b/%b",
                 $time, m_tdata, m_tlast, m_tuser);
        mismatches++;
      end else begin
        exp_px = pending_pixels.pop_front();
        if (got_px.pixel !== exp_px.pixel) begin
          $display("%0t: pixel mismatch: expected %0d, got %0d", $time, exp_px.pixel,
                   got_px.pixel);
          mismatches++;
        end
        if (got_px.eol !== exp_px.eol) begin
          $display("%0t: end_of_line mismatch: expected %b, got %b", $time, exp_px.eol,
                   got_px.eol);
          mismatches++;
        end
        if (got_px.eof !== exp_px.eof) begin
          $display("%0t: end_of_frame mismatch: expected %b, got %b", $time, exp_px.eof,
                   got_px.eof);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    width_reg = LINE_WIDTH_RESET;
    height_reg = FRAME_HEIGHT_RESET;
    clear_frame();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    src_idle = 24;
    snk_idle = 79;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) write_reg(dir_rows[i].idx, dir_rows[i].val);
      else send_sample(dir_rows[i].val, dir_rows[i].typed, dir_rows[i].res);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      src_idle = (ph < 4) ? 24 : (ph < 8) ? 79 : 0;
      snk_idle = (ph < 4) ? 79 : (ph < 8) ? 24 : 0;
      write_reg(REG_LINE_WIDTH, rand_width());
      write_reg(REG_FRAME_HEIGHT, rand_height());
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // hold off the sender until the output side has caught up
        if (n == 50) drain();
        send_sample(rand_sample(), 1'b0, '0);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/edd_pkg.sv
rtl/error_diffusion_dither.sv
tb/tb_error_diffusion_dither.sv
